FILE: hdl/swmc_pkg.sv
// Shared types and constants for the sliding-window median / cost block.
// No dependencies.
`timescale 1ns / 1ps
package swmc_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_W           = 7;   // window_length register width
  localparam int COST_EXTRA      = 7;   // total_cost is SAMPLE_BITS + 7 wide
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 3;
  localparam int REG_WINDOW      = 0;   // register index of window_length
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch sample, read/write ring slot
    logic update;   // insert/evict in sorted cells, load scan snapshot
    logic scan;     // accumulate one sorted entry
    logic finish;   // load result register
  } swmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;      // window full after this update
    logic scan_last; // last entry of the scan
    logic out_busy;  // result register still holds an untaken request
  } swmc_sts_t;

endpackage

FILE: hdl/sliding_window_median_cost_core.sv
// Sliding-window median and absolute-deviation cost, top level.
// Steps per request: accept, update, serial scan of the sorted entries, result.
// A new request is taken only once the last is done; until the window is full,
// requests skip the scan and result steps. The serial scan over the sorted cells sets the pace.
// Reset (rst_n, synchronous): window emptied, window_length back to 3.
// Depends on swmc_pkg, swmc_ctrl, swmc_dp.
`timescale 1ns / 1ps
module sliding_window_median_cost_core import swmc_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_median_value,
  output logic [SAMPLE_BITS+COST_EXTRA-1:0] out_total_cost
);

  localparam int WL_W = $clog2(MAX_WINDOW + 1);

  logic [CFG_W-1:0] wl_r;
  logic             wr;
  logic [WL_W-1:0]  win;
  swmc_cmd_t        cmd;
  swmc_sts_t        sts;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready
                  && (int'(paddr[APB_AW-1:2]) == REG_WINDOW);
  assign prdata = (int'(paddr[APB_AW-1:2]) == REG_WINDOW)
                  ? {{(APB_DW - CFG_W){1'b0}}, wl_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n)  wl_r <= WINDOW_RESET;
    else if (wr) wl_r <= pwdata[CFG_W-1:0];
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (wl_r == '0)                  win = WL_W'(1);
    else if (int'(wl_r) > MAX_WINDOW) win = WL_W'(MAX_WINDOW);
    else                             win = WL_W'(int'(wl_r));
  end

  swmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmc_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .WL_W        (WL_W),
    .COST_W      (SAMPLE_BITS + COST_EXTRA)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .win              (win),
    .flush            (wr),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_median_value (out_median_value),
    .out_total_cost   (out_total_cost)
  );

endmodule

FILE: hdl/swmc_ctrl.sv
// Sequencer for the sliding-window median block.
// Depends on swmc_pkg.
`timescale 1ns / 1ps
module swmc_ctrl import swmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  swmc_sts_t sts,
  output swmc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.emit ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/swmc_dp.sv
// Datapath: sample ring, sorted cell chain, serial cost scan, result register.
// Depends on swmc_pkg.
`timescale 1ns / 1ps
module swmc_dp import swmc_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WL_W        = $clog2(MAX_WINDOW + 1),
  parameter int COST_W      = SAMPLE_BITS + COST_EXTRA
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [WL_W-1:0]               win,
  input  logic                          flush,
  input  swmc_cmd_t                     cmd,
  output swmc_sts_t                     sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_median_value,
  output logic [COST_W-1:0]             out_total_cost
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_WINDOW + 1) + 2;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  smp_t              ring [MAX_WINDOW];
  smp_t              cell_r [MAX_WINDOW];
  smp_t              cell_nxt [MAX_WINDOW];
  smp_t              snap_r [MAX_WINDOW];
  smp_t              x_r, old_r, lo_r, hi_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [WL_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]  cnt_r;
  logic signed [ACC_W-1:0] acc_r;
  logic              out_valid_r;
  smp_t              med_r;
  logic [COST_W-1:0] cost_r;

  // evict-then-insert on the sorted cells
  smp_t t [MAX_WINDOW];
  logic rem;
  logic seen, ins;
  logic seen_v [MAX_WINDOW];
  logic ins_v  [MAX_WINDOW];
  int   n_i, m_i;

  always_comb begin
    rem  = (fill_r == win);
    n_i  = int'(fill_r);
    m_i  = rem ? int'(win) - 1 : int'(fill_r);
    seen = 1'b0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      // first match of the evicted value; none found removes the last entry
      seen      = seen | ((cell_r[i] == old_r) && (i < n_i)) | (i >= n_i - 1);
      seen_v[i] = seen;
      if (!rem || !seen) t[i] = cell_r[i];
      else if (i == MAX_WINDOW - 1) t[i] = cell_r[i];
      else t[i] = cell_r[(i + 1) % MAX_WINDOW];
    end
    ins = 1'b0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ins      = ins | ((t[i] > x_r) && (i < m_i)) | (i >= m_i);
      ins_v[i] = ins;
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (!ins_v[i])                    cell_nxt[i] = t[i];
      else if (i == 0)                  cell_nxt[i] = x_r;
      else if (!ins_v[(i + MAX_WINDOW - 1) % MAX_WINDOW]) cell_nxt[i] = x_r;
      else                              cell_nxt[i] = t[(i + MAX_WINDOW - 1) % MAX_WINDOW];
    end
    fill_nxt = rem ? win : fill_r + WL_W'(1);
  end

  // ring: one slot read and written per accepted request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_r      <= ring[ptr_r];
      ring[ptr_r] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) x_r <= in_sample;
    if (cmd.update) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        cell_r[i] <= cell_nxt[i];
        snap_r[i] <= cell_nxt[i];
      end
    end else if (cmd.scan) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) snap_r[i] <= snap_r[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (flush) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cmd.update) begin
      fill_r <= fill_nxt;
      if ({{(WL_W + 1 - PTR_W){1'b0}}, ptr_r} + (WL_W + 1)'(1) >= {1'b0, win}) ptr_r <= '0;
      else ptr_r <= ptr_r + PTR_W'(1);
    end
  end

  // serial cost scan: minus lower half, plus upper half
  int half_i, up_i;
  logic signed [ACC_W-1:0] v_ext;
  always_comb begin
    half_i = int'(win) / 2;
    up_i   = (int'(win) + 1) / 2;
    v_ext  = ACC_W'(snap_r[0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cnt_r <= '0;
      acc_r <= '0;
    end else if (cmd.scan) begin
      cnt_r <= cnt_r + PTR_W'(1);
      if (int'(cnt_r) < half_i)     acc_r <= acc_r - v_ext;
      else if (int'(cnt_r) >= up_i) acc_r <= acc_r + v_ext;
      if (int'(cnt_r) == half_i - 1) lo_r <= snap_r[0];
      if (int'(cnt_r) == half_i)     hi_r <= snap_r[0];
    end
  end

  // median: odd takes the middle, even averages toward zero
  logic signed [SAMPLE_BITS:0] msum;
  smp_t med_c;
  always_comb begin
    msum = {lo_r[SAMPLE_BITS-1], lo_r} + {hi_r[SAMPLE_BITS-1], hi_r};
    if (msum[SAMPLE_BITS] && msum[0]) msum = msum + (SAMPLE_BITS + 1)'(1);
    if (win[0]) med_c = hi_r;
    else        med_c = smp_t'(msum >>> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      med_r  <= med_c;
      cost_r <= acc_r[COST_W-1:0];
    end
  end

  always_comb begin
    sts.emit      = (fill_nxt == win);
    sts.scan_last = (int'(cnt_r) == int'(win) - 1);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = med_r;
  assign out_total_cost   = cost_r;

endmodule
